@@ src/tcc_pkg.sv @@
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types and constants of the text console engine: screen geometry,
// channel beat structs, memory port bundle, operation and state codes.
// ----------------------------------------------------------------------------
package tcc_pkg;

   // Screen geometry
   localparam int COLUMNS     = 80;
   localparam int ROWS        = 25;
   localparam int CELLS       = COLUMNS * ROWS;
   localparam int ADDR_W      = $clog2(CELLS);
   localparam int COL_W       = 7;
   localparam int ROW_W       = 5;
   localparam int LOC_W       = 12;
   localparam int COPY_LEN    = CELLS - COLUMNS;
   localparam int BOTTOM_BASE = (ROWS - 1) * COLUMNS;

   // Character and attribute constants
   localparam logic [7:0] ATTR_RESET = 8'h07;
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;

   // Request kinds
   typedef enum logic [2:0] {
      KIND_PUT_CHAR   = 3'd0,
      KIND_SET_POS    = 3'd1,
      KIND_SET_COL    = 3'd2,
      KIND_CLEAR_ROW  = 3'd3,
      KIND_CLEAR_CUR  = 3'd4,
      KIND_READ_CELL  = 3'd5
   } kind_type;

   // Memory operation left to do once any scrolls are finished
   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_WRITE = 2'd1,
      OP_WIPE  = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR = 3'd0,
      ST_IDLE  = 3'd1,
      ST_COPY  = 3'd2,
      ST_WIPE  = 3'd3,
      ST_EXEC  = 3'd4,
      ST_READ  = 3'd5,
      ST_DONE  = 3'd6
   } state_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] character;
      logic [7:0] column;
      logic [7:0] row;
   } req_type;

   typedef struct packed {
      logic [15:0]      packed_position;
      logic             cursor_written;
      logic [LOC_W-1:0] cursor_location;
      logic [15:0]      cell_value;
   } rsp_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [15:0]       wr_data;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

endpackage

@@ src/tcc_ram.sv @@
// ----------------------------------------------------------------------------
// tcc_ram
// Screen store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tcc_ram (
   input  logic                   clock,
   input  tcc_pkg::mem_req_type   mem_req,
   output logic [15:0]            rd_data_ff
);

   logic [15:0] mem [tcc_pkg::CELLS];

   // Write and read the cell array
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      rd_data_ff <= mem[mem_req.rd_addr];
   end

endmodule

@@ src/tcc_seq.sv @@
// ----------------------------------------------------------------------------
// tcc_seq
// Request sequencer: decodes a request against the cursor, then steps the
// screen store through clearing, scroll copy, line wipe, cell write or read.
// ----------------------------------------------------------------------------
module tcc_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tcc_pkg::req_type      req_data,
   input  logic [7:0]            attr,
   output logic                  res_valid,
   input  logic                  res_ready,
   output tcc_pkg::rsp_type      res_data,
   output tcc_pkg::mem_req_type  mem_req,
   input  logic [15:0]           mem_rdata
);

   localparam int AW = tcc_pkg::ADDR_W;
   localparam int CW = tcc_pkg::COL_W;
   localparam int RW = tcc_pkg::ROW_W;
   localparam int LW = tcc_pkg::LOC_W;

   tcc_pkg::state_type state_ff, state_in;
   tcc_pkg::op_type    op_ff, op_in;
   logic [AW-1:0]      cnt_ff, cnt_in;
   logic [1:0]         scroll_ff, scroll_in;
   logic [CW-1:0]      col_ff, col_in;
   logic [RW-1:0]      row_ff, row_in;
   logic [AW-1:0]      addr_ff, addr_in;
   logic [7:0]         char_ff, char_in;
   tcc_pkg::rsp_type   res_ff, res_in;

   // Decoded request
   logic [CW-1:0]      dec_col;
   logic [RW-1:0]      dec_row;
   logic [1:0]         dec_scroll;
   tcc_pkg::op_type    dec_op;
   logic               dec_written;
   logic [AW-1:0]      dec_addr;
   logic [LW-1:0]      dec_loc;

   logic               copy_last;
   logic               wipe_last;
   logic               clear_last;
   logic [AW-1:0]      wipe_base;

   assign copy_last  = (cnt_ff == AW'(tcc_pkg::COPY_LEN));
   assign wipe_last  = (cnt_ff == AW'(tcc_pkg::COLUMNS - 1));
   assign clear_last = (cnt_ff == AW'(tcc_pkg::CELLS - 1));
   assign wipe_base  = (scroll_ff != 2'd0) ? AW'(tcc_pkg::BOTTOM_BASE) : addr_ff;

   assign req_ready = (state_ff == tcc_pkg::ST_IDLE);
   assign res_valid = (state_ff == tcc_pkg::ST_DONE);
   assign res_data  = res_ff;

   // Decode the request against the current cursor
   always_comb begin : decode
      logic [RW:0]   r1;
      logic [RW:0]   r2;
      logic [RW-1:0] r1b;
      logic [RW-1:0] r2b;
      logic          sc1;
      logic          sc2;
      logic          wrap;
      logic          nl;
      logic [CW-1:0] col_pre;
      logic [RW-1:0] mul_row;
      logic [CW-1:0] mul_col;
      logic          loc_inc;
      logic [LW-1:0] sum;

      wrap    = (col_ff >= CW'(tcc_pkg::COLUMNS));
      r1      = {1'b0, row_ff} + (RW+1)'(wrap);
      sc1     = (r1 == (RW+1)'(tcc_pkg::ROWS));
      r1b     = sc1 ? RW'(tcc_pkg::ROWS - 1) : r1[RW-1:0];
      r2      = {1'b0, r1b} + (RW+1)'(1);
      sc2     = (r2 == (RW+1)'(tcc_pkg::ROWS));
      r2b     = sc2 ? RW'(tcc_pkg::ROWS - 1) : r2[RW-1:0];
      col_pre = wrap ? '0 : col_ff;
      nl      = (req_data.character == tcc_pkg::CHAR_LF) ||
                (req_data.character == tcc_pkg::CHAR_CR);

      dec_col     = col_ff;
      dec_row     = row_ff;
      dec_scroll  = 2'd0;
      dec_op      = tcc_pkg::OP_NONE;
      dec_written = 1'b0;
      mul_row     = row_ff;
      mul_col     = '0;
      loc_inc     = 1'b0;

      case (req_data.kind)
         tcc_pkg::KIND_PUT_CHAR: begin
            if (req_data.character != tcc_pkg::CHAR_NUL) begin
               dec_written = 1'b1;
               if (nl) begin
                  dec_row    = r2b;
                  dec_col    = '0;
                  dec_scroll = {1'b0, sc1} + {1'b0, sc2};
                  mul_row    = r2b;
               end else begin
                  dec_row    = r1b;
                  dec_col    = col_pre + CW'(1);
                  dec_scroll = {1'b0, sc1};
                  dec_op     = tcc_pkg::OP_WRITE;
                  mul_row    = r1b;
                  mul_col    = col_pre;
                  loc_inc    = 1'b1;
               end
            end
         end
         tcc_pkg::KIND_SET_POS: begin
            if (req_data.column <= 8'(tcc_pkg::COLUMNS)) begin
               dec_col = req_data.column[CW-1:0];
               if (req_data.row >= 8'(tcc_pkg::ROWS)) begin
                  dec_row    = RW'(tcc_pkg::ROWS - 1);
                  dec_scroll = 2'd1;
               end else begin
                  dec_row = req_data.row[RW-1:0];
               end
            end
         end
         tcc_pkg::KIND_SET_COL: begin
            if (req_data.column <= 8'(tcc_pkg::COLUMNS)) begin
               dec_col = req_data.column[CW-1:0];
            end
         end
         tcc_pkg::KIND_CLEAR_ROW: begin
            if (req_data.row < 8'(tcc_pkg::ROWS)) begin
               dec_op  = tcc_pkg::OP_WIPE;
               mul_row = req_data.row[RW-1:0];
            end
         end
         tcc_pkg::KIND_CLEAR_CUR: begin
            dec_op = tcc_pkg::OP_WIPE;
         end
         tcc_pkg::KIND_READ_CELL: begin
            if ((req_data.column < 8'(tcc_pkg::COLUMNS)) &&
                (req_data.row < 8'(tcc_pkg::ROWS))) begin
               dec_op  = tcc_pkg::OP_READ;
               mul_row = req_data.row[RW-1:0];
               mul_col = req_data.column[CW-1:0];
            end
         end
         default: begin
         end
      endcase

      sum      = LW'(mul_row) * LW'(tcc_pkg::COLUMNS) + LW'(mul_col);
      dec_addr = sum[AW-1:0];
      dec_loc  = sum + LW'(loc_inc);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tcc_pkg::ST_CLEAR: begin
            if (clear_last) state_in = tcc_pkg::ST_IDLE;
         end
         tcc_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = (dec_scroll != 2'd0) ? tcc_pkg::ST_COPY : tcc_pkg::ST_EXEC;
            end
         end
         tcc_pkg::ST_COPY: begin
            if (copy_last) state_in = tcc_pkg::ST_WIPE;
         end
         tcc_pkg::ST_WIPE: begin
            if (wipe_last) begin
               if (scroll_ff > 2'd1) begin
                  state_in = tcc_pkg::ST_COPY;
               end else if (scroll_ff == 2'd1) begin
                  state_in = tcc_pkg::ST_EXEC;
               end else begin
                  state_in = tcc_pkg::ST_DONE;
               end
            end
         end
         tcc_pkg::ST_EXEC: begin
            case (op_ff)
               tcc_pkg::OP_WIPE: state_in = tcc_pkg::ST_WIPE;
               tcc_pkg::OP_READ: state_in = tcc_pkg::ST_READ;
               default:          state_in = tcc_pkg::ST_DONE;
            endcase
         end
         tcc_pkg::ST_READ: begin
            state_in = tcc_pkg::ST_DONE;
         end
         tcc_pkg::ST_DONE: begin
            if (res_ready) state_in = tcc_pkg::ST_IDLE;
         end
         default: begin
            state_in = tcc_pkg::ST_IDLE;
         end
      endcase
   end

   // Memory accesses, counters and cursor updates
   always_comb begin
      cnt_in    = cnt_ff;
      scroll_in = scroll_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      op_in     = op_ff;
      addr_in   = addr_ff;
      char_in   = char_ff;
      res_in    = res_ff;
      mem_req   = '0;

      case (state_ff)
         tcc_pkg::ST_CLEAR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = cnt_ff;
            cnt_in          = clear_last ? '0 : cnt_ff + AW'(1);
         end
         tcc_pkg::ST_IDLE: begin
            if (req_valid) begin
               col_in                 = dec_col;
               row_in                 = dec_row;
               scroll_in              = dec_scroll;
               op_in                  = dec_op;
               addr_in                = dec_addr;
               char_in                = req_data.character;
               cnt_in                 = '0;
               res_in.packed_position = (16'(dec_row) << 8) | 16'(dec_col);
               res_in.cursor_written  = dec_written;
               res_in.cursor_location = dec_written ? dec_loc : '0;
               res_in.cell_value      = '0;
            end
         end
         tcc_pkg::ST_COPY: begin
            // Read one line ahead, write the beat read last cycle
            if (!copy_last) begin
               mem_req.rd_addr = cnt_ff + AW'(tcc_pkg::COLUMNS);
            end
            if (cnt_ff != '0) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = cnt_ff - AW'(1);
               mem_req.wr_data = mem_rdata;
            end
            cnt_in = copy_last ? '0 : cnt_ff + AW'(1);
         end
         tcc_pkg::ST_WIPE: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = wipe_base + cnt_ff;
            if (wipe_last) begin
               cnt_in = '0;
               if (scroll_ff != 2'd0) scroll_in = scroll_ff - 2'd1;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end
         tcc_pkg::ST_EXEC: begin
            cnt_in = '0;
            if (op_ff == tcc_pkg::OP_WRITE) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = addr_ff;
               mem_req.wr_data = {attr, char_ff};
            end
            mem_req.rd_addr = addr_ff;
         end
         tcc_pkg::ST_READ: begin
            res_in.cell_value = mem_rdata;
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= tcc_pkg::ST_CLEAR;
         op_ff     <= tcc_pkg::OP_NONE;
         cnt_ff    <= '0;
         scroll_ff <= 2'd0;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         op_ff     <= op_in;
         cnt_ff    <= cnt_in;
         scroll_ff <= scroll_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      char_ff <= char_in;
      res_ff  <= res_in;
   end

endmodule

@@ src/text_console_cursor_scroll.sv @@
// ----------------------------------------------------------------------------
// text_console_cursor_scroll
// Text-mode console engine: screen store of attribute/character cells with a
// cursor, scrolling, line clearing and cell read-back.
// ----------------------------------------------------------------------------
// After reset the block sweeps all COLUMNS x ROWS cells of the screen store
// to zero, one cell a cycle, and takes no request until that ends;
// attribute writes are taken at any time. The store is a single memory with
// one write and one registered read port, and every request is worked
// through it in turn. A request that only moves the cursor or writes one
// cell passes through the execute and done states, a cell read also through
// the read state, and a line clear wipes its line one cell a cycle. Each
// scroll copies lines 1..24 up one line through the read port, then wipes
// the bottom line; a wrapped newline on the bottom line scrolls twice.
// A finished result sits in an output register, so the next request can be
// accepted while the result waits to be taken.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tcc_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tcc_pkg::rsp_type  rsp_data,
   input  logic              csr_write_enable,
   input  logic [7:0]        csr_write_data
);

   logic [7:0]           attr_ff, attr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   tcc_pkg::rsp_type     rsp_ff, rsp_in;
   logic                 res_valid;
   logic                 res_ready;
   tcc_pkg::rsp_type     res_data;
   tcc_pkg::mem_req_type mem_req;
   logic [15:0]          mem_rdata;

   tcc_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .attr      (attr_ff),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_data  (res_data),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );

   tcc_ram u_ram (
      .clock      (clock),
      .mem_req    (mem_req),
      .rd_data_ff (mem_rdata)
   );

   // Attribute register
   assign attr_in = csr_write_enable ? csr_write_data : attr_ff;

   // Output register: load when empty or being drained, drop on take
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res_data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff      <= tcc_pkg::ATTR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         attr_ff      <= attr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
